[src/weighted_histogram_binner_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the weighted histogram binner
// Clocked assertions with reset qualification, reported through $error.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_HISTOGRAM_BINNER_UNIT_MACROS_SVH
`define WEIGHTED_HISTOGRAM_BINNER_UNIT_MACROS_SVH

// same-cycle implication
`define WHR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WHR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/whr_pkg.sv]
// ----------------------------------------------------------------------------
// whr_pkg
// Shared constants and types of the weighted histogram binner.
// ----------------------------------------------------------------------------
package whr_pkg;

   localparam int NUM_BINS    = 256;
   localparam int SUM_BITS    = 48;
   localparam int IDX_W       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int Q_W         = IDX_W + 1;           // quotient bits resolved by the divider
   localparam int DVS_W       = 31 + Q_W;            // widest shifted divisor
   localparam int STEP_W      = $clog2(Q_W);
   localparam int QUEUE_DEPTH = 2;

   localparam int VALUE_W  = 32;
   localparam int WEIGHT_W = 32;
   localparam int BIN_IN_W = 8;
   localparam int MIN_W    = 32;
   localparam int WIDTH_W  = 31;
   localparam int COUNT_W  = 9;
   localparam int OUT_SUM_W = 48;
   localparam int OUT_HIT_W = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [MIN_W-1:0]   MIN_RESET   = '0;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 31'd65536;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

   typedef enum logic {
      REQ_ADD  = 1'b0,
      REQ_READ = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIN_MIN   = 2'd0,
      CSR_BIN_WIDTH = 2'd1,
      CSR_BIN_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [MIN_W-1:0]   bin_min;
      logic [WIDTH_W-1:0] bin_width;
      logic [COUNT_W-1:0] bin_count;
   } cfg_type;

   // classified work item handed from front to back
   typedef struct packed {
      req_kind_type           kind;
      logic                   live;     // add inside a bin, or read of an existing bin
      logic [IDX_W-1:0]       idx;
      logic [OUT_HIT_W-1:0]   hit;
      logic [WEIGHT_W-1:0]    weight;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[src/weighted_histogram_binner_unit.sv]
// ----------------------------------------------------------------------------
// weighted_histogram_binner_unit
// Weighted histogram over equal-width signed Q16.16 bins with saturating
// sums and read-and-clear of single bins.
//
//   channel | role       | handshake                  | payload
//   req_    | requests   | tvalid / tready            | tdata, tuser
//   rsp_    | results    | tvalid / tready            | tdata, tuser
//   csr_    | reg writes | valid / ready (always set) | index, data
//
// Add: the front accepts it, runs 9 divider steps of the restoring divider,
// which resolves one quotient bit per cycle, then pushes it to the queue;
// an add that falls outside the range skips the divider. Read: accept, then
// queue push. The back reads the RAM, then updates, one item at a time, and
// overlaps the front through a 2-entry queue. Reset clears all bins at once
// through per-bin valid bits. A stalled response holds the back, the full
// queue then holds the front.
// ----------------------------------------------------------------------------
module weighted_histogram_binner_unit (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: sample_value [31:0], sample_weight [63:32], read_bin [71:64]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [71:0]                         req_tdata,
   // req_tuser: req_type [0]
   input  logic                                req_tuser,
   // rsp_tdata: bin_sum [47:0], bin_hit [55:48]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [55:0]                         rsp_tdata,
   // rsp_tuser: counted [0], saturated [1]
   output logic [1:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [whr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [whr_pkg::CSR_DAT_W-1:0]       csr_data
);

   whr_pkg::cfg_type           cfg_ff, cfg_in;
   logic                       push;
   whr_pkg::entry_type         push_entry;
   logic                       pop;
   whr_pkg::entry_type         head;
   whr_pkg::queue_status_type  q_status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            whr_pkg::CSR_BIN_MIN:   cfg_in.bin_min   = csr_data[whr_pkg::MIN_W-1:0];
            whr_pkg::CSR_BIN_WIDTH: cfg_in.bin_width = csr_data[whr_pkg::WIDTH_W-1:0];
            whr_pkg::CSR_BIN_COUNT: cfg_in.bin_count = csr_data[whr_pkg::COUNT_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bin_min   <= whr_pkg::MIN_RESET;
         cfg_ff.bin_width <= whr_pkg::WIDTH_RESET;
         cfg_ff.bin_count <= whr_pkg::COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   whr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_entry (push_entry),
      .q_status   (q_status)
   );

   whr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   whr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[src/whr_ram.sv]
// ----------------------------------------------------------------------------
// whr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module whr_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/whr_queue.sv]
// ----------------------------------------------------------------------------
// whr_queue
// Short FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module whr_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  whr_pkg::entry_type        push_entry,
   input  logic                      pop,
   output whr_pkg::entry_type        head,
   output whr_pkg::queue_status_type status
);

   localparam int PTR_W = (whr_pkg::QUEUE_DEPTH > 1) ? $clog2(whr_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(whr_pkg::QUEUE_DEPTH + 1);

   whr_pkg::entry_type slot_ff [whr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign status.full  = (cnt_ff == CNT_W'(whr_pkg::QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head    = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(whr_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(whr_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

[src/whr_front.sv]
// ----------------------------------------------------------------------------
// whr_front
// Accepts requests and classifies them; adds in range go through a restoring
// divider that resolves one quotient bit per cycle to find the bin.
// ----------------------------------------------------------------------------
module whr_front (
   input  logic                                clock,
   input  logic                                reset,
   input  whr_pkg::cfg_type                    cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [whr_pkg::VALUE_W+whr_pkg::WEIGHT_W+whr_pkg::BIN_IN_W-1:0] req_tdata,
   input  logic                                req_tuser,
   output logic                                push,
   output whr_pkg::entry_type                  push_entry,
   input  whr_pkg::queue_status_type           q_status
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type               state_ff, state_in;
   whr_pkg::entry_type            entry_ff, entry_in;
   logic [31:0]                   rem_ff, rem_in;
   logic [whr_pkg::DVS_W-1:0]     dvs_ff, dvs_in;
   logic [whr_pkg::Q_W-1:0]       quo_ff, quo_in;
   logic [whr_pkg::STEP_W-1:0]    step_ff, step_in;

   logic [whr_pkg::VALUE_W-1:0]   value;
   logic [whr_pkg::WEIGHT_W-1:0]  weight;
   logic [whr_pkg::BIN_IN_W-1:0]  read_bin;
   logic                          accept;
   logic [32:0]                   diff;
   logic                          diff_pos;
   logic                          in_range;
   logic                          ge;
   logic [31:0]                   rem_nx;
   logic [whr_pkg::Q_W-1:0]       quo_nx;
   logic [31:0]                   used;

   assign value    = req_tdata[whr_pkg::VALUE_W-1:0];
   assign weight   = req_tdata[whr_pkg::VALUE_W +: whr_pkg::WEIGHT_W];
   assign read_bin = req_tdata[whr_pkg::VALUE_W+whr_pkg::WEIGHT_W +: whr_pkg::BIN_IN_W];

   assign req_tready = (state_ff == F_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign push       = (state_ff == F_PUSH);
   assign push_entry = entry_ff;

   // value - bin_min, exact in 33 bits
   assign diff     = {value[31], value} - {cfg.bin_min[31], cfg.bin_min};
   assign diff_pos = !diff[32] && (diff != '0);
   // quotient must fit in Q_W bits, otherwise the bin is out of range anyway
   assign in_range = diff_pos && (cfg.bin_width != '0) &&
                     ({{(whr_pkg::DVS_W-32){1'b0}}, diff[31:0]} <
                      {cfg.bin_width, {whr_pkg::Q_W{1'b0}}});

   assign ge     = (whr_pkg::DVS_W'(rem_ff) >= dvs_ff);
   assign rem_nx = ge ? (rem_ff - dvs_ff[31:0]) : rem_ff;
   assign quo_nx = {quo_ff[whr_pkg::Q_W-2:0], ge};
   assign used   = (32'(cfg.bin_count) > 32'(whr_pkg::NUM_BINS)) ?
                   32'(whr_pkg::NUM_BINS) : 32'(cfg.bin_count);

   always_comb begin
      state_in = state_ff;
      entry_in = entry_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               entry_in.weight = weight;
               if (req_tuser == whr_pkg::REQ_READ) begin
                  entry_in.kind = whr_pkg::REQ_READ;
                  entry_in.live = (32'(read_bin) < 32'(whr_pkg::NUM_BINS));
                  entry_in.idx  = whr_pkg::IDX_W'(read_bin);
                  entry_in.hit  = read_bin;
                  state_in      = F_PUSH;
               end else begin
                  entry_in.kind = whr_pkg::REQ_ADD;
                  entry_in.live = 1'b0;
                  entry_in.idx  = '0;
                  entry_in.hit  = '0;
                  rem_in        = diff[31:0];
                  dvs_in        = whr_pkg::DVS_W'(cfg.bin_width) << (whr_pkg::Q_W - 1);
                  quo_in        = '0;
                  step_in       = whr_pkg::STEP_W'(whr_pkg::Q_W - 1);
                  state_in      = in_range ? F_DIV : F_PUSH;
               end
            end
         end
         F_DIV: begin
            rem_in  = rem_nx;
            quo_in  = quo_nx;
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               // on an edge when the remainder is zero
               if ((rem_nx != '0) && (32'(quo_nx) < used)) begin
                  entry_in.live = 1'b1;
                  entry_in.idx  = whr_pkg::IDX_W'(quo_nx);
                  entry_in.hit  = whr_pkg::OUT_HIT_W'(quo_nx);
               end
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_status.full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
   end

endmodule

[src/whr_back.sv]
// ----------------------------------------------------------------------------
// whr_back
// Carries out queued entries: read-modify-write of the bin sums with
// saturation, read-and-clear, and the registered response stage.
// ----------------------------------------------------------------------------
module whr_back (
   input  logic                                clock,
   input  logic                                reset,
   input  whr_pkg::entry_type                  head,
   input  whr_pkg::queue_status_type           q_status,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [whr_pkg::OUT_SUM_W+whr_pkg::OUT_HIT_W-1:0] rsp_tdata,
   output logic [1:0]                          rsp_tuser
);

   typedef enum logic [1:0] {
      B_IDLE   = 2'b01,
      B_UPDATE = 2'b10
   } back_state_type;

   back_state_type                      state_ff, state_in;
   whr_pkg::entry_type                  cur_ff;
   logic                                was_vld_ff;
   logic [whr_pkg::NUM_BINS-1:0]        vld_ff, vld_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [whr_pkg::OUT_SUM_W-1:0]       rsp_sum_ff, rsp_sum_in;
   logic [whr_pkg::OUT_HIT_W-1:0]       rsp_hit_ff, rsp_hit_in;
   logic                                rsp_cnt_ff, rsp_cnt_in;
   logic                                rsp_sat_ff, rsp_sat_in;

   logic                                out_free;
   logic                                finish;
   logic [whr_pkg::SUM_BITS-1:0]        ram_rdata;
   logic [whr_pkg::SUM_BITS-1:0]        old_sum;
   logic [whr_pkg::SUM_BITS:0]          total;
   logic                                sat;
   logic [whr_pkg::SUM_BITS-1:0]        new_sum;
   logic                                wr_en;
   logic [whr_pkg::SUM_BITS-1:0]        wr_data;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign pop      = (state_ff == B_IDLE) && !q_status.empty;
   assign finish   = (state_ff == B_UPDATE) && out_free;

   // entries never written since reset read as zero
   assign old_sum = was_vld_ff ? ram_rdata : '0;
   assign total   = {1'b0, old_sum} + (whr_pkg::SUM_BITS+1)'(cur_ff.weight);
   assign sat     = total[whr_pkg::SUM_BITS];
   assign new_sum = sat ? '1 : total[whr_pkg::SUM_BITS-1:0];

   assign wr_en   = finish && cur_ff.live;
   assign wr_data = (cur_ff.kind == whr_pkg::REQ_READ) ? '0 : new_sum;

   whr_ram #(
      .WIDTH (whr_pkg::SUM_BITS),
      .DEPTH (whr_pkg::NUM_BINS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_ff.idx),
      .wr_data (wr_data),
      .rd_en   (pop),
      .rd_addr (head.idx),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      vld_in       = vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_sat_in   = rsp_sat_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop) begin
               state_in = B_UPDATE;
            end
         end
         B_UPDATE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = cur_ff.hit;
               if (cur_ff.kind == whr_pkg::REQ_READ) begin
                  rsp_sum_in = cur_ff.live ? whr_pkg::OUT_SUM_W'(old_sum) : '0;
                  rsp_cnt_in = 1'b0;
                  rsp_sat_in = 1'b0;
               end else begin
                  rsp_sum_in = cur_ff.live ? whr_pkg::OUT_SUM_W'(new_sum) : '0;
                  rsp_cnt_in = cur_ff.live;
                  rsp_sat_in = cur_ff.live && sat;
               end
               if (cur_ff.live) begin
                  vld_in[cur_ff.idx] = 1'b1;
               end
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff     <= head;
         was_vld_ff <= vld_ff[head.idx];
      end
      rsp_sum_ff <= rsp_sum_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_hit_ff, rsp_sum_ff};
   assign rsp_tuser  = {rsp_sat_ff, rsp_cnt_ff};

endmodule

[src/whr_checker.sv]
// ----------------------------------------------------------------------------
// whr_checker
// Port-level checks of the weighted histogram binner, bound to the top level.
// ----------------------------------------------------------------------------
`include "weighted_histogram_binner_unit_macros.svh"

module whr_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [55:0]                         rsp_tdata,
   input  logic [1:0]                          rsp_tuser
);

   // a held result keeps its contents
   `WHR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // only a counted add can clip
   `WHR_ASSERT_NOW(a_sat_counted, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0], "saturated without counted")

   // a clipped sum sits at the maximum
   `WHR_ASSERT_NOW(a_sat_max, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tdata[47:0] == 48'hFFFF_FFFF_FFFF, "saturated sum below maximum")

   // one request at a time: the input closes after each transfer
   `WHR_ASSERT_NEXT(a_req_one, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")

endmodule

bind weighted_histogram_binner_unit whr_checker u_checker (.*);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the weighted histogram binner. Requests go in on
// the req_ stream and results come back on rsp_. A scoreboard mirrors the
// register settings and the 256 bin sums and predicts every result. It runs
// directed edge and range cases, then random phases over a range of bin
// settings, with random stalls on both sides and one phase with no idling.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [47:0] sum;
   logic [7:0]  hit;
   logic        counted;
   logic        saturated;
} bin_report_type;

class histogram_scoreboard;
   localparam logic [47:0] SUM_CEILING = {48{1'b1}};

   logic signed [31:0] lo_edge = '0;
   logic [30:0]        step    = 31'd65536;
   logic [8:0]         n_bins  = 9'd256;
   logic [47:0]        sums [whr_pkg::NUM_BINS];
   bin_report_type     awaited [$];
   int                 mismatches = 0;

   function new();
      foreach (sums[i]) sums[i] = '0;
   endfunction

   function void set_reg(whr_pkg::csr_index_type idx, logic [31:0] data);
      case (idx)
         whr_pkg::CSR_BIN_MIN:   lo_edge = data;
         whr_pkg::CSR_BIN_WIDTH: step    = data[30:0];
         whr_pkg::CSR_BIN_COUNT: n_bins  = data[8:0];
         default: ;
      endcase
   endfunction

   function void note_request(whr_pkg::req_kind_type kind, logic [31:0] value,
                              logic [31:0] weight, logic [7:0] rbin);
      bin_report_type r;
      longint      diff, span, quot, rest, limit;
      logic [47:0] room;
      r = '0;
      if (kind == whr_pkg::REQ_READ) begin
         r.hit = rbin;
         r.sum = sums[rbin];
         sums[rbin] = '0;
      end else begin
         diff  = longint'($signed(value)) - longint'(lo_edge);
         span  = longint'(step);
         limit = (n_bins > whr_pkg::NUM_BINS) ? whr_pkg::NUM_BINS : n_bins;
         // open intervals only: a value on an edge leaves a zero remainder
         if (span != 0 && diff > 0) begin
            quot = diff / span;
            rest = diff % span;
            if (rest != 0 && quot < limit) begin
               room = SUM_CEILING - sums[quot];
               if (weight > room) begin
                  sums[quot]  = SUM_CEILING;
                  r.saturated = 1'b1;
               end else begin
                  sums[quot] = sums[quot] + weight;
               end
               r.sum     = sums[quot];
               r.hit     = quot[7:0];
               r.counted = 1'b1;
            end
         end
      end
      awaited.push_back(r);
   endfunction

   function void check_result(logic [55:0] data, logic [1:0] flags);
      bin_report_type want;
      if (awaited.size() == 0) begin
         $error("result transfer with nothing outstanding: tdata %h tuser %b", data, flags);
         mismatches++;
      end else begin
         want = awaited.pop_front();
         if (data[47:0] !== want.sum) begin
            $error("bin_sum: expected %0d, got %0d", want.sum, data[47:0]);
            mismatches++;
         end
         if (data[55:48] !== want.hit) begin
            $error("bin_hit: expected %0d, got %0d", want.hit, data[55:48]);
            mismatches++;
         end
         if (flags[0] !== want.counted) begin
            $error("counted: expected %b, got %b", want.counted, flags[0]);
            mismatches++;
         end
         if (flags[1] !== want.saturated) begin
            $error("saturated: expected %b, got %b", want.saturated, flags[1]);
            mismatches++;
         end
      end
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [71:0]                   req_tdata  = '0;
   logic                          req_tuser  = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [55:0]                   rsp_tdata;
   logic [1:0]                    rsp_tuser;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [whr_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [whr_pkg::CSR_DAT_W-1:0] csr_data   = '0;

   histogram_scoreboard book = new();

   bit       req_idle_on  = 1'b1;
   bit       rsp_idle_on  = 1'b1;
   int       stall_asks   = 0;
   int       stall_served = 0;
   int       hold_left    = 0;
   logic [7:0] last_bin   = '0;

   weighted_histogram_binner_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_result(rsp_tdata, rsp_tuser);
   end

   // result side: random backpressure, plus a long hold-off on request
   initial begin
      @(negedge clock);
      forever begin
         if (stall_asks != stall_served) begin
            stall_served = stall_served + 1;
            hold_left    = 400;
         end
         if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_idle_on) begin
            rsp_tready <= ($urandom_range(99) >= 38);
         end else begin
            rsp_tready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(whr_pkg::req_kind_type kind, logic [31:0] value,
                            logic [31:0] weight, logic [7:0] rbin);
      if (req_idle_on) begin
         while ($urandom_range(99) < 38) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rbin, weight, value};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      book.note_request(kind, value, weight, rbin);
      @(negedge clock);
   endtask

   task automatic send_add(logic [31:0] value, logic [31:0] weight);
      send_item(whr_pkg::REQ_ADD, value, weight, 8'($urandom));
   endtask

   task automatic send_read(logic [7:0] rbin);
      send_item(whr_pkg::REQ_READ, $urandom, $urandom, rbin);
   endtask

   task automatic write_reg(whr_pkg::csr_index_type idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      book.set_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (book.awaited.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(logic [31:0] lo, logic [31:0] wdata, logic [31:0] cdata);
      drain();
      write_reg(whr_pkg::CSR_BIN_MIN, lo);
      write_reg(whr_pkg::CSR_BIN_WIDTH, wdata);
      write_reg(whr_pkg::CSR_BIN_COUNT, cdata);
   endtask

   task automatic run_phase(int items);
      int          roll;
      longint      span, used, lane, off;
      logic [31:0] value, weight;
      for (int n = 0; n < items; n++) begin
         roll = $urandom_range(99);
         case ($urandom_range(9))
            0:       weight = '0;
            1:       weight = 32'hFFFF_FFFF;
            default: weight = $urandom;
         endcase
         if (roll < 15) begin
            send_read(($urandom_range(2) == 0) ? last_bin : 8'($urandom));
         end else if (roll < 25) begin
            send_add($urandom, weight);
         end else begin
            // aim at a bin, on its lower edge for some of them
            span = longint'(book.step);
            used = (book.n_bins > whr_pkg::NUM_BINS) ? whr_pkg::NUM_BINS : book.n_bins;
            if (used == 0) used = 1;
            lane = $urandom_range(32'(used - 1));
            off  = (roll < 33 || span < 2) ? 0 : 1 + longint'($urandom) % (span - 1);
            value    = 32'(longint'(book.lo_edge) + span * lane + off);
            last_bin = lane[7:0];
            send_add(value, weight);
         end
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: min 0, width 1.0, 256 bins
      send_add(32'd1, 32'd5);
      send_add(32'd0, 32'd7);
      send_add(32'h0001_0000, 32'd7);
      send_add(32'h8000_0000, 32'd7);
      send_add(32'h7FFF_FFFF, 32'd7);
      send_add(32'h00FF_0001, 32'hFFFF_FFFF);
      send_add(32'h00FF_FFFF, 32'd1);
      send_add(32'h0100_0005, 32'd7);
      send_add(32'h0003_8000, 32'd0);
      send_read(8'd0);
      send_read(8'd255);
      send_read(8'd255);
      send_read(8'd3);
      send_read(8'd128);

      // widest bins from the most negative edge
      configure(32'h8000_0000, 32'h7FFF_FFFF, 32'd3);
      send_add(32'h7FFF_FFFF, $urandom);
      send_add(32'h8000_0001, $urandom);
      send_add(32'h8000_0000, $urandom);
      send_add(32'hFFFF_FFFF, $urandom);
      send_read(8'd2);

      configure(32'd0, 32'h8000_0000, 32'd256);   // width field zero
      send_add(32'h0001_8000, 32'd9);
      configure(32'd0, 32'h0001_0000, 32'd0);     // no bins
      send_add(32'h0001_8000, 32'd9);
      send_read(8'd1);
      configure(32'd0, 32'h0001_0000, 32'hFFFF_FFFF);  // count above the bin array
      send_add(32'h00FF_8000, 32'd9);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: configure(32'h8000_0000, 32'h7FFF_FFFF, 32'd511);
            1: configure($urandom, 32'd1, 32'd256);
            2: configure(32'(-$urandom_range(524288)), 32'($urandom_range(262144, 2)),
                         32'($urandom_range(256, 1)));
            3: configure($urandom, 32'h8000_0000, 32'd256);
            4: configure($urandom_range(65535), 32'h0001_0000, 32'd0);
            5: configure($urandom, {1'($urandom), 31'($urandom_range(200000, 2))},
                         {23'($urandom), 9'($urandom_range(256, 1))});
            6: configure($urandom, $urandom, $urandom);
            default: configure(32'h7FFF_0000, 32'h0000_0100, 32'd255);
         endcase
         req_idle_on = (p != 5);
         rsp_idle_on = (p != 5);
         if (p == 2) stall_asks = stall_asks + 1;
         if (p == 1 || p == 3 || p == 4) begin
            run_phase(60);
         end else if (p == 6) begin
            run_phase(80);
            drain();
            run_phase(85);
         end else begin
            run_phase(165);
         end
      end

      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      drain();
      repeat (40) @(negedge clock);
      if (book.mismatches == 0 && book.awaited.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
